[rtl/scs_pkg.sv]
// shared types, constants and state encoding for the shadow call stack unwinder
`timescale 1ns / 1ps

package scs_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_NUM_THREADS = 4;

    // fixed field widths
    localparam int THREAD_W    = 2;
    localparam int WORD_W      = 64;
    localparam int DEPTH_OUT_W = 7;

    // transaction kinds on func
    localparam logic FUNC_CALL = 1'b0;
    localparam logic FUNC_RET  = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // one saved frame as kept in the frame memory
    typedef struct packed {
        word_t entry;
        word_t sp;
    } frame_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN
    } scs_state_t;

endpackage

[rtl/scs_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/shadow_call_stack_unwinder.sv]
// shadow call stack unwinder top level: sequencer, depth counters and frame memory
//
//  channel   | handshake             | signals
//  ----------+-----------------------+--------------------------------------------------
//  command   | start && !busy        | func, thread, call_target, stack_pointer
//  result    | done (one cycle)      | matched, matched_entry, matched_sp,
//            |                       | depth_after, overflow
//
// a call, an invalid thread or a return on an empty stack goes from accept through
// S_DISPATCH to done; a return on a non-empty stack then scans in S_SCAN, k = frames
// compared (1..STACK_DEPTH), set by the one 64-bit compare that walks the frame memory one
// frame per cycle
// busy stays high from accept until the result cycle; a new transaction may be
// accepted in the cycle done is high
// reset clears the per-thread depth counters; the frame memory needs no clearing
// the receiver cannot stall: done is a single-cycle strobe
`timescale 1ns / 1ps

module shadow_call_stack_unwinder
    import scs_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int NUM_THREADS = DEF_NUM_THREADS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  logic [THREAD_W-1:0]    thread,
    input  logic [WORD_W-1:0]      call_target,
    input  logic [WORD_W-1:0]      stack_pointer,
    output logic                   done,
    output logic                   matched,
    output logic [WORD_W-1:0]      matched_entry,
    output logic [WORD_W-1:0]      matched_sp,
    output logic [DEPTH_OUT_W-1:0] depth_after,
    output logic                   overflow
);

    // only threads reachable through the thread field get a stack
    localparam int NT_USED   = (NUM_THREADS < 2**THREAD_W) ? NUM_THREADS : 2**THREAD_W;
    localparam int TIDX_W    = (NT_USED > 1) ? $clog2(NT_USED) : 1;
    localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W     = $clog2(STACK_DEPTH);
    localparam int MEM_DEPTH = NT_USED * STACK_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    scs_state_t state_reg, state_next;

    logic                   func_reg, func_next;
    logic [TIDX_W-1:0]      tidx_reg, tidx_next;
    logic                   tok_reg, tok_next;
    word_t                  target_reg, target_next;
    word_t                  sp_reg, sp_next;
    logic [MEM_AW-1:0]      base_reg, base_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [DEPTH_W-1:0]     depth_reg [NT_USED];
    logic [DEPTH_W-1:0]     depth_next [NT_USED];

    logic                   done_reg, done_next;
    logic                   matched_reg, matched_next;
    word_t                  mentry_reg, mentry_next;
    word_t                  msp_reg, msp_next;
    logic [DEPTH_W-1:0]     dafter_reg, dafter_next;
    logic                   ovf_reg, ovf_next;

    logic                   accept;
    logic                   thread_ok;
    logic [TIDX_W-1:0]      thread_idx;
    logic [DEPTH_W-1:0]     depth_cur;
    logic [DEPTH_W-1:0]     idx_ext;
    logic                   sp_below;

    logic                   ram_we;
    logic [MEM_AW-1:0]      ram_waddr;
    logic [MEM_AW-1:0]      ram_raddr;
    frame_t                 ram_wdata;
    frame_t                 ram_rdata;

    // frame memory: one row per thread, STACK_DEPTH frames per row
    scs_ram #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (MEM_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and thread decode
    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign thread_ok  = (32'(thread) < NUM_THREADS);
    assign thread_idx = thread[TIDX_W-1:0];
    assign depth_cur  = depth_reg[tidx_reg];
    assign idx_ext    = DEPTH_W'(idx_reg);

    // shared compare unit: saved sp below sp after return
    assign sp_below = (ram_rdata.sp < sp_reg);

    // sequencer next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        tidx_next    = tidx_reg;
        tok_next     = tok_reg;
        target_next  = target_reg;
        sp_next      = sp_reg;
        base_next    = base_reg;
        idx_next     = idx_reg;
        depth_next   = depth_reg;
        done_next    = 1'b0;
        matched_next = matched_reg;
        mentry_next  = mentry_reg;
        msp_next     = msp_reg;
        dafter_next  = dafter_reg;
        ovf_next     = ovf_reg;
        ram_we       = 1'b0;
        ram_waddr    = base_reg + MEM_AW'(depth_cur);
        ram_wdata    = '{entry: target_reg, sp: sp_reg};
        ram_raddr    = base_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func;
                    tidx_next   = thread_ok ? thread_idx : '0;
                    tok_next    = thread_ok;
                    target_next = call_target;
                    sp_next     = stack_pointer;
                    base_next   = thread_ok ? MEM_AW'(thread_idx * STACK_DEPTH) : '0;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                idx_next     = '0;
                matched_next = 1'b0;
                mentry_next  = '0;
                msp_next     = '0;
                ovf_next     = 1'b0;
                dafter_next  = depth_cur;
                if (!tok_reg)
                begin
                    // thread with no stack: all-zero result
                    dafter_next = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (func_reg == FUNC_CALL)
                begin
                    if (depth_cur == DEPTH_W'(STACK_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we               = 1'b1;
                        depth_next[tidx_reg] = depth_cur + 1'b1;
                        dafter_next          = depth_cur + 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (depth_cur == '0)
                begin
                    // return on an empty stack
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // oldest frame read is issued now
                    ram_raddr  = base_reg;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                ram_raddr = base_reg + MEM_AW'(idx_reg) + 1'b1;
                if (sp_below)
                begin
                    matched_next         = 1'b1;
                    mentry_next          = ram_rdata.entry;
                    msp_next             = ram_rdata.sp;
                    depth_next[tidx_reg] = idx_ext;
                    dafter_next          = idx_ext;
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (idx_ext + 1'b1 == depth_cur)
                begin
                    // walked the whole stack with no match
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int t = 0; t < NT_USED; t++)
            begin
                depth_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            depth_reg <= depth_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        tidx_reg    <= tidx_next;
        tok_reg     <= tok_next;
        target_reg  <= target_next;
        sp_reg      <= sp_next;
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        matched_reg <= matched_next;
        mentry_reg  <= mentry_next;
        msp_reg     <= msp_next;
        dafter_reg  <= dafter_next;
        ovf_reg     <= ovf_next;
    end

    // result ports
    assign done          = done_reg;
    assign matched       = matched_reg;
    assign matched_entry = mentry_reg;
    assign matched_sp    = msp_reg;
    assign depth_after   = DEPTH_OUT_W'(dafter_reg);
    assign overflow      = ovf_reg;

    // a result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != S_IDLE))
        else $error("result strobe without a transaction in flight");

    // a transaction never both matches and overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(matched && overflow))
        else $error("matched and overflow set together");

    // a match only comes from a return
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && matched) |-> (func_reg == FUNC_RET))
        else $error("match reported for a call");

    // the scan index stays inside the live frames
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_ext < depth_cur))
        else $error("scan index beyond stack depth");

    // the selected stack never grows past its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (depth_cur <= DEPTH_W'(STACK_DEPTH)))
        else $error("stack depth above capacity");

endmodule

[tb/sv/shadow_call_stack_checker.sv]
// checker for the shadow call stack unwinder: watches both channels, predicts and compares
`timescale 1ns / 1ps

module shadow_call_stack_checker
    import scs_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int NUM_THREADS = DEF_NUM_THREADS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   func,
    input  logic [THREAD_W-1:0]    thread,
    input  logic [WORD_W-1:0]      call_target,
    input  logic [WORD_W-1:0]      stack_pointer,
    input  logic                   done,
    input  logic                   matched,
    input  logic [WORD_W-1:0]      matched_entry,
    input  logic [WORD_W-1:0]      matched_sp,
    input  logic [DEPTH_OUT_W-1:0] depth_after,
    input  logic                   overflow,
    output int                     mismatch_count,
    output int                     results_due
);

    // one predicted result transaction
    typedef struct packed {
        logic                   matched;
        word_t                  entry;
        word_t                  sp;
        logic [DEPTH_OUT_W-1:0] depth;
        logic                   overflow;
    } unwind_result_t;

    // predicted per-thread shadow stacks
    word_t shadow_entry [NUM_THREADS][STACK_DEPTH];
    word_t shadow_sp    [NUM_THREADS][STACK_DEPTH];
    int    shadow_depth [NUM_THREADS];

    unwind_result_t unwind_queue [$];
    int             fails = 0;

    // push on call, scan from the oldest frame on return
    task automatic predict_unwind(
        input  logic                kind,
        input  logic [THREAD_W-1:0] tid,
        input  word_t               target,
        input  word_t               sp,
        output unwind_result_t      res
    );
        int  d;
        logic hit;
        res = '0;
        hit = 1'b0;
        if (int'(tid) < NUM_THREADS)
        begin
            d = shadow_depth[tid];
            if (kind == FUNC_CALL)
            begin
                if (d < STACK_DEPTH)
                begin
                    shadow_entry[tid][d] = target;
                    shadow_sp[tid][d]    = sp;
                    d++;
                end
                else
                begin
                    res.overflow = 1'b1;
                end
            end
            else
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                begin
                    if (!hit && i < d && shadow_sp[tid][i] < sp)
                    begin
                        hit         = 1'b1;
                        res.matched = 1'b1;
                        res.entry   = shadow_entry[tid][i];
                        res.sp      = shadow_sp[tid][i];
                        d           = i;
                    end
                end
            end
            shadow_depth[tid] = d;
            res.depth = DEPTH_OUT_W'(d);
        end
    endtask

    task automatic report_field(input string field, input word_t want, input word_t got);
        if (got !== want)
        begin
            $display("t=%0t %s mismatch: expected %h actual %h", $time, field, want, got);
            fails++;
        end
    endtask

    // result transactions are checked before the command of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin : track
        unwind_result_t want;
        unwind_result_t got;
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_THREADS; t++)
            begin
                shadow_depth[t] = 0;
            end
            unwind_queue.delete();
        end
        else
        begin
            if (done)
            begin
                got = {matched, matched_entry, matched_sp, depth_after, overflow};
                if (unwind_queue.size() == 0)
                begin
                    $display("t=%0t unexpected result: expected none actual %h", $time, got);
                    fails++;
                end
                else
                begin
                    want = unwind_queue.pop_front();
                    report_field("matched", want.matched, got.matched);
                    report_field("matched_entry", want.entry, got.entry);
                    report_field("matched_sp", want.sp, got.sp);
                    report_field("depth_after", want.depth, got.depth);
                    report_field("overflow", want.overflow, got.overflow);
                end
            end
            if (start && !busy)
            begin
                predict_unwind(func, thread, call_target, stack_pointer, want);
                // append at the tail of the queue
                unwind_queue = {unwind_queue, want};
            end
        end
        mismatch_count <= fails;
        results_due    <= unwind_queue.size();
    end

endmodule

[tb/sv/tb_shadow_call_stack_unwinder.sv]
// testbench top for the shadow call stack unwinder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_shadow_call_stack_unwinder;
    import scs_pkg::*;

    localparam int ITEM_COUNT       = 1500;
    localparam int MAX_GAP          = 40;
    localparam int SETTLE_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int STACK_DEPTH_FILL = DEF_STACK_DEPTH;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   func;
    logic [THREAD_W-1:0]    thread;
    logic [WORD_W-1:0]      call_target;
    logic [WORD_W-1:0]      stack_pointer;
    logic                   done;
    logic                   matched;
    logic [WORD_W-1:0]      matched_entry;
    logic [WORD_W-1:0]      matched_sp;
    logic [DEPTH_OUT_W-1:0] depth_after;
    logic                   overflow;

    int mismatch_count;
    int results_due;
    int idle_pct = 0;
    int sent = 0;
    int quiet_cycles = 0;

    // per-thread stack pointer walk used to shape well-formed call chains
    word_t sp_base   [DEF_NUM_THREADS];
    word_t sp_cursor [DEF_NUM_THREADS];

    shadow_call_stack_unwinder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .thread        (thread),
        .call_target   (call_target),
        .stack_pointer (stack_pointer),
        .done          (done),
        .matched       (matched),
        .matched_entry (matched_entry),
        .matched_sp    (matched_sp),
        .depth_after   (depth_after),
        .overflow      (overflow)
    );

    shadow_call_stack_checker unwind_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .thread         (thread),
        .call_target    (call_target),
        .stack_pointer  (stack_pointer),
        .done           (done),
        .matched        (matched),
        .matched_entry  (matched_entry),
        .matched_sp     (matched_sp),
        .depth_after    (depth_after),
        .overflow       (overflow),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // field values biased toward the extremes
    function automatic word_t pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return word_t'($urandom_range(0, 255));
            default: return rand_word();
        endcase
    endfunction

    // one command transaction, preceded by a random idle gap
    task automatic issue(
        input logic                kind,
        input logic [THREAD_W-1:0] tid,
        input word_t               target,
        input word_t               sp
    );
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        func          <= kind;
        thread        <= tid;
        call_target   <= target;
        stack_pointer <= sp;
        do @(posedge clk); while (busy !== 1'b0);
        sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    // call chains, unwinds, deep fills past the top and random noise
    task automatic run_chain(input int chain_no);
        logic [THREAD_W-1:0] tid;
        int                  calls;
        int                  rets;
        int                  roll;
        word_t               ret_sp;
        tid  = THREAD_W'($urandom_range(0, DEF_NUM_THREADS - 1));
        roll = $urandom_range(99);
        if (chain_no % 25 == 3)
        begin
            // fill past a full stack, then unwind part way
            calls = STACK_DEPTH_FILL + $urandom_range(1, 4);
            for (int i = 0; i < calls; i++)
            begin
                sp_cursor[tid] -= word_t'($urandom_range(1, 4));
                issue(FUNC_CALL, tid, rand_word(), sp_cursor[tid]);
            end
            ret_sp = sp_cursor[tid] + word_t'($urandom_range(0, 300));
            issue(FUNC_RET, tid, rand_word(), ret_sp);
            sp_cursor[tid] = ret_sp;
        end
        else if (roll < 50)
        begin
            // nested calls followed by some returns
            calls = $urandom_range(1, 8);
            rets  = $urandom_range(0, calls);
            for (int i = 0; i < calls; i++)
            begin
                sp_cursor[tid] -= word_t'($urandom_range(1, 64));
                issue(FUNC_CALL, tid, rand_word(), sp_cursor[tid]);
            end
            for (int i = 0; i < rets; i++)
            begin
                ret_sp = sp_cursor[tid] + word_t'($urandom_range(0, 96));
                issue(FUNC_RET, tid, rand_word(), ret_sp);
                sp_cursor[tid] = ret_sp;
            end
        end
        else if (roll < 65)
        begin
            // unwind to the oldest frame, sometimes with a fresh base
            if ($urandom_range(3) == 0)
            begin
                issue(FUNC_RET, tid, rand_word(), '1);
                sp_base[tid] = rand_word() | 64'h0000_0000_0100_0000;
            end
            else
            begin
                issue(FUNC_RET, tid, rand_word(), sp_base[tid] + word_t'($urandom_range(0, 16)));
            end
            sp_cursor[tid] = sp_base[tid];
        end
        else
        begin
            // noise: any kind, any thread, extreme or random fields
            calls = $urandom_range(1, 4);
            for (int i = 0; i < calls; i++)
            begin
                issue(logic'($urandom_range(0, 1)), THREAD_W'($urandom_range(0, 3)),
                      pick_word(), pick_word());
            end
        end
    endtask

    initial
    begin
        int chain_no;
        int phase_end;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FUNC_CALL;
        thread        = '0;
        call_target   = '0;
        stack_pointer = '0;
        chain_no      = 0;
        for (int t = 0; t < DEF_NUM_THREADS; t++)
        begin
            sp_base[t]   = rand_word() | 64'h0000_0000_0100_0000;
            sp_cursor[t] = sp_base[t];
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stack, equal and adjacent stack pointers, extremes
        issue(FUNC_RET,  2'd0, '0, '1);
        issue(FUNC_CALL, 2'd0, '0, '0);
        issue(FUNC_RET,  2'd0, '1, '0);
        issue(FUNC_RET,  2'd0, '0, 64'd1);
        issue(FUNC_CALL, 2'd1, '1, '1);
        issue(FUNC_CALL, 2'd1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(FUNC_CALL, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        issue(FUNC_RET,  2'd1, '0, 64'h5555_5555_5555_5555);
        issue(FUNC_RET,  2'd1, '0, '1);
        issue(FUNC_RET,  2'd1, '0, '1);
        issue(FUNC_CALL, 2'd2, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        issue(FUNC_CALL, 2'd2, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF);
        issue(FUNC_RET,  2'd2, '0, 64'h8000_0000_0000_0001);
        issue(FUNC_CALL, 2'd3, 64'h0123_4567_89AB_CDEF, 64'h1000);
        issue(FUNC_CALL, 2'd3, 64'hFEDC_BA98_7654_3210, 64'h0F00);
        issue(FUNC_RET,  2'd3, '0, 64'h0F80);
        issue(FUNC_CALL, 2'd3, rand_word(), 64'h0FFF);
        issue(FUNC_RET,  2'd3, '0, '1);
        issue(FUNC_RET,  2'd1, '1, '0);
        issue(FUNC_RET,  2'd2, '1, '0);
        wait_for_results();

        // random chains in phases of different sender idling
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 26 : 0;
            phase_end = sent + ITEM_COUNT / 4;
            while (sent < phase_end)
            begin
                run_chain(chain_no);
                chain_no++;
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
